// File: hdl/lz77_stream_decompressor_core_assert.svh
// Assertion macros shared by the decompressor checks.
`ifndef LZ77_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH
`define LZ77_STREAM_DECOMPRESSOR_CORE_ASSERT_SVH

// same-cycle implication
`define LZSD_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("lzsd port check failed");

// next-cycle implication
`define LZSD_ASSERT_NXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("lzsd port check failed");

`endif

// File: hdl/lzsd_pkg.sv
// Types and constants shared by the decompressor modules.
`default_nettype none
package lzsd_pkg;

  localparam int WIN_BITS        = 12;
  localparam int WIN_DEPTH       = 1 << WIN_BITS;
  localparam int HDR_BITS        = 24;
  localparam int CNT_BITS        = 5;
  localparam int Q_PTR_BITS      = 2;
  localparam int Q_DEPTH         = 1 << Q_PTR_BITS;
  localparam int LEN_BIAS        = 3;
  localparam int TOKENS_PER_FLAG = 8;
  localparam logic [7:0] FLAG_REF_MASK = 8'h80;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_last;
  } out_word_t;

  // one decoded token for the copy engine
  typedef struct packed {
    logic                is_ref;
    logic [7:0]          lit;
    logic [CNT_BITS-1:0] count;    // bytes to emit, 1..18
    logic [WIN_BITS-1:0] dist_m1;  // distance minus one
    logic                last;     // final byte of the stream
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic empty;
    cmd_t cmd;
  } q_rd_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FLAG,
    PH_TOKEN,
    PH_REF2
  } parse_phase_t;

  typedef enum logic [1:0] {
    CP_FETCH,
    CP_READ,
    CP_EMIT
  } copy_state_t;

endpackage
`default_nettype wire

// File: hdl/lzsd_parse.sv
// Front end: header, flag and token parsing into copy commands.
`default_nettype none
module lzsd_parse #(
  parameter int LENGTH_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lzsd_pkg::in_word_t in_data,
  input  logic               q_full,
  output lzsd_pkg::q_wr_t    q_wr
);
  import lzsd_pkg::*;

  parse_phase_t           phase, phase_next;
  logic [1:0]             header_index, header_index_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [7:0]             flag_bits, flag_bits_next;
  logic [2:0]             token_index, token_index_next;
  logic [7:0]             held, held_next;

  logic                   accept;
  logic [7:0]             b;
  logic                   is_ref_tok;
  logic [4:0]             hdr_shift;
  logic [HDR_BITS-1:0]    hdr_acc;
  logic [CNT_BITS-1:0]    len_ext;
  logic [CNT_BITS-1:0]    ref_count;
  logic [LENGTH_BITS-1:0] rem_after_ref;
  logic [LENGTH_BITS-1:0] rem_after_lit;
  logic [LENGTH_BITS-1:0] rem_emit;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign b          = in_data.in_byte;
  assign is_ref_tok = (flag_bits & FLAG_REF_MASK) != 8'h00;

  always_comb begin
    case (header_index)
      2'd1:    hdr_shift = 5'd0;
      2'd2:    hdr_shift = 5'd8;
      default: hdr_shift = 5'd16;
    endcase
    hdr_acc = HDR_BITS'(remaining) | (HDR_BITS'(b) << hdr_shift);
  end

  assign len_ext       = CNT_BITS'(held[7:4]) + CNT_BITS'(LEN_BIAS);
  assign ref_count     = (remaining < LENGTH_BITS'(len_ext)) ?
                         remaining[CNT_BITS-1:0] : len_ext;
  assign rem_after_ref = remaining - LENGTH_BITS'(ref_count);
  assign rem_after_lit = remaining - LENGTH_BITS'(1);
  assign rem_emit      = (phase == PH_REF2) ? rem_after_ref : rem_after_lit;

  // next state
  always_comb begin
    phase_next        = phase;
    header_index_next = header_index;
    remaining_next    = remaining;
    flag_bits_next    = flag_bits;
    token_index_next  = token_index;
    held_next         = held;
    if (accept) begin
      if (in_data.stream_start) begin
        phase_next        = PH_HEADER;
        header_index_next = 2'd1;
        remaining_next    = '0;
        flag_bits_next    = '0;
        token_index_next  = '0;
        held_next         = '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            remaining_next = hdr_acc[LENGTH_BITS-1:0];
            if (header_index == 2'd3) begin
              header_index_next = 2'd0;
              phase_next = (hdr_acc[LENGTH_BITS-1:0] == '0) ? PH_IDLE : PH_FLAG;
            end else begin
              header_index_next = header_index + 2'd1;
            end
          end
          PH_FLAG: begin
            flag_bits_next   = b;
            token_index_next = '0;
            phase_next       = PH_TOKEN;
          end
          PH_TOKEN, PH_REF2: begin
            if (phase == PH_TOKEN && is_ref_tok) begin
              held_next  = b;
              phase_next = PH_REF2;
            end else begin
              remaining_next = rem_emit;
              if (rem_emit == '0) begin
                phase_next = PH_IDLE;
              end else begin
                flag_bits_next = {flag_bits[6:0], 1'b0};
                if (token_index == 3'(TOKENS_PER_FLAG - 1)) begin
                  token_index_next = '0;
                  phase_next       = PH_FLAG;
                end else begin
                  token_index_next = token_index + 3'd1;
                  phase_next       = PH_TOKEN;
                end
              end
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  // command out
  always_comb begin
    q_wr.push        = accept && !in_data.stream_start &&
                       ((phase == PH_TOKEN && !is_ref_tok) || phase == PH_REF2);
    q_wr.cmd.is_ref  = (phase == PH_REF2);
    q_wr.cmd.lit     = b;
    q_wr.cmd.dist_m1 = {held[3:0], b};
    if (phase == PH_REF2) begin
      q_wr.cmd.count = ref_count;
      q_wr.cmd.last  = (rem_after_ref == '0);
    end else begin
      q_wr.cmd.count = CNT_BITS'(1);
      q_wr.cmd.last  = (rem_after_lit == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      header_index <= '0;
      remaining    <= '0;
      flag_bits    <= '0;
      token_index  <= '0;
      held         <= '0;
    end else begin
      phase        <= phase_next;
      header_index <= header_index_next;
      remaining    <= remaining_next;
      flag_bits    <= flag_bits_next;
      token_index  <= token_index_next;
      held         <= held_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/lzsd_fifo.sv
// Short command queue between the parser and the copy engine.
`default_nettype none
module lzsd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  lzsd_pkg::q_wr_t q_wr,
  output logic            q_full,
  input  logic            pop,
  output lzsd_pkg::q_rd_t q_rd
);
  import lzsd_pkg::*;

  cmd_t                  slots [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr;
  logic [Q_PTR_BITS-1:0] rd_ptr;
  logic [Q_PTR_BITS:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign q_full     = (count == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign q_rd.empty = (count == '0);
  assign q_rd.cmd   = slots[rd_ptr];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = pop && !q_rd.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wr.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hdl/lzsd_copy.sv
// Back end: history window, copy engine and output register.
`default_nettype none
module lzsd_copy (
  input  logic                clk,
  input  logic                rst,
  input  lzsd_pkg::q_rd_t     q_rd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lzsd_pkg::out_word_t out_data
);
  import lzsd_pkg::*;

  copy_state_t         state, state_next;
  cmd_t                cur;
  logic [CNT_BITS-1:0] left;
  logic [WIN_BITS-1:0] wp;
  logic                wrapped;   // every window entry written at least once
  logic                rd_ok;
  logic [7:0]          mem_q;
  logic [7:0]          hist [WIN_DEPTH];

  logic [WIN_BITS-1:0] raddr;
  logic                rd_en;
  logic                fire;
  logic [7:0]          byte_sel;

  assign raddr    = wp - cur.dist_m1 - WIN_BITS'(1);
  assign byte_sel = cur.is_ref ? (rd_ok ? mem_q : 8'h00) : cur.lit;

  // outputs
  always_comb begin
    pop   = 1'b0;
    rd_en = 1'b0;
    fire  = 1'b0;
    case (state)
      CP_FETCH: pop   = !q_rd.empty;
      CP_READ:  rd_en = 1'b1;
      CP_EMIT:  fire  = !out_valid || out_ready;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      CP_FETCH: if (!q_rd.empty) state_next = q_rd.cmd.is_ref ? CP_READ : CP_EMIT;
      CP_READ:  state_next = CP_EMIT;
      CP_EMIT:  if (fire) state_next = (left == CNT_BITS'(1)) ? CP_FETCH : CP_READ;
      default:  state_next = CP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hist[wp] <= byte_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= hist[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur  <= q_rd.cmd;
      left <= q_rd.cmd.count;
    end else if (fire) begin
      left <= left - CNT_BITS'(1);
    end
    // entries not yet written since reset read as zero
    if (rd_en) begin
      rd_ok <= wrapped || (raddr < wp);
    end
    if (fire) begin
      out_data.out_byte <= byte_sel;
      out_data.is_last  <= cur.last && (left == CNT_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CP_FETCH;
      wp        <= '0;
      wrapped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        wp <= wp + WIN_BITS'(1);
        if (wp == '1) wrapped <= 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/lz77_stream_decompressor_core.sv
// Top level of the LZ77 stream decompressor.
// Input channel (in_valid/in_ready/in_data): one compressed byte per word;
// stream_start marks the type byte of a new header and abandons any stream
// in progress. Output channel (out_valid/out_ready/out_data): one
// decompressed byte per word, is_last set on the byte that completes the
// header length. Bytes outside a stream produce nothing.
// The parser takes a byte every cycle while the 4-entry command queue has
// room. The copy engine handles a literal in a fetch state and an emit
// state, and a back-reference in a fetch state followed by one window read
// and one write/emit per byte; the window is a single-port 4096-byte
// memory, so reads and writes fall in separate states. A literal passes
// the command queue, the fetch state and the emit state on its way out.
// Reset empties the queue and output register and restarts the window
// write pointer; window entries not yet written since reset read as zero,
// tracked by a wrap flag, so no clearing pass is needed.
// When out_ready is low the output word holds, the copy engine waits, the
// queue fills and in_ready drops.
`default_nettype none
module lz77_stream_decompressor_core #(
  parameter int LENGTH_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lzsd_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lzsd_pkg::out_word_t out_data
);
  import lzsd_pkg::*;

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  pop;

  lzsd_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data (in_data),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  lzsd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .q_wr  (q_wr),
    .q_full(q_full),
    .pop   (pop),
    .q_rd  (q_rd)
  );

  lzsd_copy u_copy (
    .clk      (clk),
    .rst      (rst),
    .q_rd     (q_rd),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: hdl/lzsd_checker.sv
// Port-level checks for the decompressor, bound to the top level.
`default_nettype none
`include "lz77_stream_decompressor_core_assert.svh"
module lzsd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input lzsd_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lzsd_pkg::out_word_t out_data
);

  // reset empties the queue and the output register
  `LZSD_ASSERT_NXT(a_rst_clear, clk, 1'b0, rst, !out_valid && in_ready)
  // reset keeps the output empty until a word has passed the queue and copy engine
  `LZSD_ASSERT_IMP(a_rst_latency, clk, 1'b0, $past(rst, 2), !out_valid)
  // queue only fills on an accepted word
  `LZSD_ASSERT_IMP(a_ready_drop, clk, rst, $fell(in_ready), $past(in_valid && in_ready))
  `LZSD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_data))

endmodule

bind lz77_stream_decompressor_core lzsd_checker u_lzsd_checker (.*);
`default_nettype wire
